[design/sst_pkg.sv]
// Shared types and constants for the Sobel structure tensor window block.
// Used by sst_div and sobel_structure_tensor_window; depends on nothing.
package sst_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned REG_W      = 12;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ACC_W      = 43;
  localparam int unsigned ACCS_W     = 44;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned FRAC_SH    = 10;                 // 65536 / 64
  localparam int unsigned DIV_W      = ACC_W + FRAC_SH;    // dividend bits
  localparam int unsigned Q_W        = 30;
  localparam int unsigned INFO_W     = 44;

  // configuration register indexes
  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_ROW_FIRST = 3'd2;
  localparam logic [2:0] REG_ROW_END   = 3'd3;
  localparam logic [2:0] REG_COL_FIRST = 3'd4;
  localparam logic [2:0] REG_COL_END   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DIV_XX,
    ST_DIV_XY,
    ST_DIV_YY,
    ST_PROD,
    ST_INFO,
    ST_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [CNT_W-1:0]   divisor;
  } div_req_t;

  // divider status
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

endpackage

[design/sst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/sst_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sst_pkg.
module sst_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sst_pkg::div_req_t req_i,
  output sst_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(sst_pkg::DIV_W + 1);

  logic [sst_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [sst_pkg::CNT_W-1:0] den_q, den_d;
  logic [sst_pkg::CNT_W:0]   rem_q, rem_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [sst_pkg::CNT_W:0]   rem_sh;

  // load a new request, else one shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q[sst_pkg::CNT_W-1:0], quo_q[sst_pkg::DIV_W-1]};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      den_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CW'(sst_pkg::DIV_W);
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[sst_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[sst_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[design/sobel_structure_tensor_window.sv]
// Top level: Sobel structure tensor over a box of a raster gray image.
// Depends on sst_pkg, sst_ram (line stores) and sst_div (final divisions).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o   | pixel_i, frame_start_i
//  out      | out_valid_o / out_stall_i | tensor_xx/xy/yy, information, count
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each pixel passes through accept, line store read, multiply and
// accumulate; no new pixel is taken until the block is idle again. The
// two line stores share one RAM word. At frame end, unless the box is empty,
// three divisions run on one shared divider, then products; then the result loads.
// The result sits in an output register; a stalled result holds the block
// only when the next frame result is ready. Reset clears control, window
// and sums; line store contents stay undefined until written.
module sobel_structure_tensor_window (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        pixel_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [29:0]                       tensor_xx_o,
  output logic signed [30:0]                tensor_xy_o,
  output logic [29:0]                       tensor_yy_o,
  output logic [43:0]                       information_o,
  output logic [22:0]                       pixel_count_o,
  output logic                              region_empty_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [11:0]                       cfg_data_i
);

  localparam int unsigned COL_W = sst_pkg::COL_W;
  localparam int unsigned ROW_W = sst_pkg::ROW_W;
  localparam int unsigned REG_W = sst_pkg::REG_W;
  localparam int unsigned PIX_W = sst_pkg::PIX_W;

  sst_pkg::state_e state_q, state_d;

  // configuration registers
  logic [REG_W-1:0] width_q, height_q, rfirst_q, rend_q, cfirst_q, cend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_W'(sst_pkg::MAX_WIDTH);
      height_q <= REG_W'(sst_pkg::MAX_HEIGHT);
      rfirst_q <= REG_W'(1);
      rend_q   <= REG_W'(2048);
      cfirst_q <= REG_W'(1);
      cend_q   <= REG_W'(2048);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sst_pkg::REG_WIDTH:     width_q  <= cfg_data_i;
        sst_pkg::REG_HEIGHT:    height_q <= cfg_data_i;
        sst_pkg::REG_ROW_FIRST: rfirst_q <= cfg_data_i;
        sst_pkg::REG_ROW_END:   rend_q   <= cfg_data_i;
        sst_pkg::REG_COL_FIRST: cfirst_q <= cfg_data_i;
        sst_pkg::REG_COL_END:   cend_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped size and box
  logic [REG_W-1:0] w_eff, h_eff, r0, r1, c0, c1;
  always_comb begin
    w_eff = (width_q < REG_W'(3)) ? REG_W'(3) :
            (width_q > REG_W'(sst_pkg::MAX_WIDTH)) ? REG_W'(sst_pkg::MAX_WIDTH) : width_q;
    h_eff = (height_q < REG_W'(3)) ? REG_W'(3) :
            (height_q > REG_W'(sst_pkg::MAX_HEIGHT)) ? REG_W'(sst_pkg::MAX_HEIGHT) : height_q;
    r0 = (rfirst_q < REG_W'(1)) ? REG_W'(1) : rfirst_q;
    r1 = (rend_q < h_eff - 1'b1) ? rend_q : h_eff - 1'b1;
    c0 = (cfirst_q < REG_W'(1)) ? REG_W'(1) : cfirst_q;
    c1 = (cend_q < w_eff - 1'b1) ? cend_q : w_eff - 1'b1;
  end

  logic accept;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != sst_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == sst_pkg::ST_IDLE);

  // position of the incoming pixel and the next position
  logic [COL_W-1:0] col_q, col_cur, col_d, cur_col_q;
  logic [ROW_W-1:0] row_q, row_cur, row_d, cur_row_q;
  logic             eof_d, eof_q;
  logic [PIX_W-1:0] pix_q;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    eof_d   = 1'b0;
    if ({1'b0, col_cur} + 1'b1 < w_eff) begin
      col_d = col_cur + 1'b1;
      row_d = row_cur;
    end else begin
      col_d = '0;
      if ({1'b0, row_cur} + 1'b1 < h_eff) begin
        row_d = row_cur + 1'b1;
      end else begin
        row_d = '0;
        eof_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      eof_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      eof_q <= eof_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q     <= pixel_i;
      cur_col_q <= col_cur;
      cur_row_q <= row_cur;
    end
  end

  // line stores: upper in the high byte, middle in the low byte
  logic [2*PIX_W-1:0] ram_rdata;
  logic               ram_we;
  logic [PIX_W-1:0]   top_r, mid_r;

  assign ram_we = (state_q == sst_pkg::ST_READ);
  assign top_r  = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid_r  = ram_rdata[PIX_W-1:0];

  sst_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (sst_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_col_q),
    .wdata_i ({mid_r, pix_q}),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // window: top_l, top_c, mid_l, mid_c, bot_l, bot_c
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (state_q == sst_pkg::ST_READ) begin
      win_q[0] <= win_q[1];
      win_q[1] <= top_r;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_r;
      win_q[4] <= win_q[5];
      win_q[5] <= pix_q;
    end
  end

  // gradients and box test
  logic signed [11:0] gx, gy, gx_q, gy_q;
  logic               use_d, use_q;
  logic [REG_W-1:0]   ci, cj;

  always_comb begin
    gx = (12'(top_r) - 12'(win_q[0])) + ((12'(mid_r) - 12'(win_q[2])) <<< 1)
       + (12'(pix_q) - 12'(win_q[4]));
    gy = (12'(win_q[4]) - 12'(win_q[0])) + ((12'(win_q[5]) - 12'(win_q[1])) <<< 1)
       + (12'(pix_q) - 12'(top_r));
    ci = REG_W'(cur_row_q) - 1'b1;
    cj = REG_W'(cur_col_q) - 1'b1;
    use_d = (cur_row_q >= ROW_W'(2)) && (cur_col_q >= COL_W'(2)) &&
            (ci >= r0) && (ci < r1) && (cj >= c0) && (cj < c1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sst_pkg::ST_READ) begin
      gx_q <= gx;
      gy_q <= gy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 1'b0;
    end else if (state_q == sst_pkg::ST_READ) begin
      use_q <= use_d;
    end
  end

  // products
  logic signed [23:0] pxx_q, pxy_q, pyy_q;
  always_ff @(posedge clk_i) begin
    if (state_q == sst_pkg::ST_MUL) begin
      pxx_q <= 24'(gx_q) * 24'(gx_q);
      pxy_q <= 24'(gx_q) * 24'(gy_q);
      pyy_q <= 24'(gy_q) * 24'(gy_q);
    end
  end

  // accumulators
  logic [sst_pkg::ACC_W-1:0]         acc_xx_q, acc_yy_q;
  logic signed [sst_pkg::ACCS_W-1:0] acc_xy_q;
  logic [sst_pkg::CNT_W-1:0]         cnt_q;
  logic                              clear_sums;

  assign clear_sums = (accept && frame_start_i) ||
                      (state_q == sst_pkg::ST_OUT && state_d == sst_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_xx_q <= '0;
      acc_xy_q <= '0;
      acc_yy_q <= '0;
      cnt_q    <= '0;
    end else if (clear_sums) begin
      acc_xx_q <= '0;
      acc_xy_q <= '0;
      acc_yy_q <= '0;
      cnt_q    <= '0;
    end else if (state_q == sst_pkg::ST_ACC && use_q) begin
      acc_xx_q <= acc_xx_q + sst_pkg::ACC_W'(pxx_q);
      acc_xy_q <= acc_xy_q + sst_pkg::ACCS_W'(pxy_q);
      acc_yy_q <= acc_yy_q + sst_pkg::ACC_W'(pyy_q);
      cnt_q    <= cnt_q + 1'b1;
    end
  end

  // frame-end divisions on the shared divider
  sst_pkg::div_req_t div_req;
  sst_pkg::div_rsp_t div_rsp;
  logic              div_started_q;
  logic              xy_neg;
  logic [sst_pkg::ACC_W-1:0] xy_mag;

  assign xy_neg = acc_xy_q[sst_pkg::ACCS_W-1];
  assign xy_mag = sst_pkg::ACC_W'(xy_neg ? -acc_xy_q : acc_xy_q);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.divisor  = cnt_q;
    div_req.dividend = {acc_xx_q, {sst_pkg::FRAC_SH{1'b0}}};
    case (state_q)
      sst_pkg::ST_DIV_XX: begin
        div_req.start = !div_started_q;
      end
      sst_pkg::ST_DIV_XY: begin
        div_req.start    = !div_started_q;
        div_req.dividend = {xy_mag, {sst_pkg::FRAC_SH{1'b0}}};
      end
      sst_pkg::ST_DIV_YY: begin
        div_req.start    = !div_started_q;
        div_req.dividend = {acc_yy_q, {sst_pkg::FRAC_SH{1'b0}}};
      end
      default: ;
    endcase
  end

  sst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_started_q <= 1'b0;
    end else if (div_rsp.done) begin
      div_started_q <= 1'b0;
    end else if (div_req.start) begin
      div_started_q <= 1'b1;
    end
  end

  logic [sst_pkg::Q_W-1:0]    qxx_q, qmag_q, qyy_q;
  logic [2*sst_pkg::Q_W-1:0]  p_q, m_q;
  logic [sst_pkg::INFO_W-1:0] info_q;

  always_ff @(posedge clk_i) begin
    if (div_rsp.done) begin
      case (state_q)
        sst_pkg::ST_DIV_XX: qxx_q  <= div_rsp.quotient[sst_pkg::Q_W-1:0];
        sst_pkg::ST_DIV_XY: qmag_q <= div_rsp.quotient[sst_pkg::Q_W-1:0];
        sst_pkg::ST_DIV_YY: qyy_q  <= div_rsp.quotient[sst_pkg::Q_W-1:0];
        default: ;
      endcase
    end
    if (state_q == sst_pkg::ST_PROD) begin
      p_q <= qxx_q * qyy_q;
      m_q <= qmag_q * qmag_q;
    end
    if (state_q == sst_pkg::ST_INFO) begin
      info_q <= (p_q > m_q) ? sst_pkg::INFO_W'((p_q - m_q) >> 16) : '0;
    end
  end

  // next state
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sst_pkg::ST_IDLE:   if (accept) state_d = sst_pkg::ST_READ;
      sst_pkg::ST_READ:   state_d = sst_pkg::ST_MUL;
      sst_pkg::ST_MUL:    state_d = sst_pkg::ST_ACC;
      sst_pkg::ST_ACC: begin
        if (!eof_q) begin
          state_d = sst_pkg::ST_IDLE;
        end else if (cnt_q == '0 && !use_q) begin
          state_d = sst_pkg::ST_OUT;
        end else begin
          state_d = sst_pkg::ST_DIV_XX;
        end
      end
      sst_pkg::ST_DIV_XX: if (div_rsp.done) state_d = sst_pkg::ST_DIV_XY;
      sst_pkg::ST_DIV_XY: if (div_rsp.done) state_d = sst_pkg::ST_DIV_YY;
      sst_pkg::ST_DIV_YY: if (div_rsp.done) state_d = sst_pkg::ST_PROD;
      sst_pkg::ST_PROD:   state_d = sst_pkg::ST_INFO;
      sst_pkg::ST_INFO:   state_d = sst_pkg::ST_OUT;
      sst_pkg::ST_OUT:    if (out_free) state_d = sst_pkg::ST_IDLE;
      default:            state_d = sst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic load_out, empty;
  assign load_out = (state_q == sst_pkg::ST_OUT) && out_free;
  assign empty    = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      tensor_xx_o    <= empty ? '0 : qxx_q;
      tensor_yy_o    <= empty ? '0 : qyy_q;
      tensor_xy_o    <= empty ? '0 :
                        (xy_neg ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q}));
      information_o  <= empty ? '0 : info_q;
      pixel_count_o  <= cnt_q;
      region_empty_o <= empty;
    end
  end

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && region_empty_o) |-> (tensor_xx_o == '0 && pixel_count_o == '0
      && information_o == '0))
    else $error("empty region result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !region_empty_o) |-> (pixel_count_o != '0))
    else $error("nonempty result with zero count");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && state_q == sst_pkg::ST_READ))
    else $error("pixel accepted without line store read");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule
